// ===== src/stsc_pkg.sv =====
// ----------------------------------------------------------------------------
// stsc_pkg: shared types and constants of the source token scanner
// Scanner modes, token codes and the result record used by every module.
// ----------------------------------------------------------------------------
`default_nettype none

package stsc_pkg;

    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_OP    = 3'd1,
        MODE_WORD  = 3'd2,
        MODE_STR   = 3'd3,
        MODE_INT   = 3'd4,
        MODE_LOCK  = 3'd5
    } t_mode;

    localparam int unsigned CODE_W = 6;
    localparam int unsigned NUM_W  = 31;

    localparam logic [CODE_W-1:0] TK_SEMI     = 6'd0;
    localparam logic [CODE_W-1:0] TK_LPAREN   = 6'd1;
    localparam logic [CODE_W-1:0] TK_RPAREN   = 6'd2;
    localparam logic [CODE_W-1:0] TK_LBRACE   = 6'd3;
    localparam logic [CODE_W-1:0] TK_RBRACE   = 6'd4;
    localparam logic [CODE_W-1:0] TK_STAR     = 6'd5;
    localparam logic [CODE_W-1:0] TK_SLASH    = 6'd6;
    localparam logic [CODE_W-1:0] TK_COMMA    = 6'd7;
    localparam logic [CODE_W-1:0] TK_ASSIGN   = 6'd8;
    localparam logic [CODE_W-1:0] TK_EQ       = 6'd9;
    localparam logic [CODE_W-1:0] TK_LT       = 6'd10;
    localparam logic [CODE_W-1:0] TK_GT       = 6'd11;
    localparam logic [CODE_W-1:0] TK_LE       = 6'd12;
    localparam logic [CODE_W-1:0] TK_GE       = 6'd13;
    localparam logic [CODE_W-1:0] TK_NOT      = 6'd14;
    localparam logic [CODE_W-1:0] TK_NE       = 6'd15;
    localparam logic [CODE_W-1:0] TK_ANDAND   = 6'd16;
    localparam logic [CODE_W-1:0] TK_OROR     = 6'd17;
    localparam logic [CODE_W-1:0] TK_PLUS     = 6'd18;
    localparam logic [CODE_W-1:0] TK_MINUS    = 6'd19;
    localparam logic [CODE_W-1:0] TK_PLUSEQ   = 6'd20;
    localparam logic [CODE_W-1:0] TK_INCR     = 6'd21;
    localparam logic [CODE_W-1:0] TK_MINUSEQ  = 6'd22;
    localparam logic [CODE_W-1:0] TK_BAD_OP   = 6'd23;
    localparam logic [CODE_W-1:0] TK_IDENT    = 6'd24;
    localparam logic [CODE_W-1:0] TK_KW_INT   = 6'd25;
    localparam logic [CODE_W-1:0] TK_KW_STR   = 6'd26;
    localparam logic [CODE_W-1:0] TK_KW_VOID  = 6'd27;
    localparam logic [CODE_W-1:0] TK_KW_PRINT = 6'd28;
    localparam logic [CODE_W-1:0] TK_KW_IF    = 6'd29;
    localparam logic [CODE_W-1:0] TK_KW_ELSE  = 6'd30;
    localparam logic [CODE_W-1:0] TK_KW_FOR   = 6'd31;
    localparam logic [CODE_W-1:0] TK_KW_FUNC  = 6'd32;
    localparam logic [CODE_W-1:0] TK_KW_PROC  = 6'd33;
    localparam logic [CODE_W-1:0] TK_KW_THRD  = 6'd34;
    localparam logic [CODE_W-1:0] TK_KW_RET   = 6'd35;
    localparam logic [CODE_W-1:0] TK_KW_AWAIT = 6'd36;
    localparam logic [CODE_W-1:0] TK_STRING   = 6'd37;
    localparam logic [CODE_W-1:0] TK_INTVAL   = 6'd38;
    localparam logic [CODE_W-1:0] TK_END      = 6'd39;
    localparam logic [CODE_W-1:0] TK_ERROR    = 6'd41;

    localparam logic [NUM_W-1:0] NUM_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic              kind;
        logic [CODE_W-1:0] token_code;
        logic [NUM_W-1:0]  int_result;
        logic [7:0]        text_char;
        logic              last;
    } t_res;

    typedef struct packed {
        logic [1:0] n;
        t_res       r0;
        t_res       r1;
    } t_push;

endpackage

`default_nettype wire

// ===== src/stsc_if.sv =====
// ----------------------------------------------------------------------------
// stsc_if: channel interfaces of the source token scanner
// Source byte channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface stsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_end;

    modport source (output valid, output in_byte, output is_end, input ready);
    modport sink   (input valid, input in_byte, input is_end, output ready);
endinterface

interface stsc_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [5:0]  token_code;
    logic [30:0] int_result;
    logic [7:0]  text_char;
    logic        last;

    modport source (output valid, output kind, output token_code, output int_result,
                    output text_char, output last, input ready);
    modport sink   (input valid, input kind, input token_code, input int_result,
                    input text_char, input last, output ready);
endinterface

`default_nettype wire

// ===== src/source_token_scanner.sv =====
// ----------------------------------------------------------------------------
// source_token_scanner: streaming lexical scanner
// One source byte or end marker in, up to two token or text results out.
//
//   channel   port    dir   payload
//   source    i_in    in    in_byte[7:0], is_end
//   result    o_out   out   kind, token_code[5:0], int_result[30:0],
//                           text_char[7:0], last
//
// A byte is taken into the input register, decoded there once the queue has
// room for two results, and its results pushed into a four-entry queue. One
// byte per cycle while each gives at most one result and the output takes
// them; bytes with two results are paced by the single queue read port.
// Synchronous reset returns the scanner to start mode with an empty queue.
// A stalled output fills the queue and then holds off the input.
// ----------------------------------------------------------------------------
`default_nettype none

module source_token_scanner
    import stsc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    stsc_in_if.sink      i_in,
    stsc_out_if.source   o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       room, fire;
    t_push      push;
    t_res       res;

    assign fire       = r_in_valid && room;
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
            r_in_end  <= i_in.is_end;
        end
    end

    stsc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_push  (push)
    );

    stsc_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out.valid),
        .o_res   (res),
        .i_ready (o_out.ready)
    );

    assign o_out.kind       = res.kind;
    assign o_out.token_code = res.token_code;
    assign o_out.int_result = res.int_result;
    assign o_out.text_char  = res.text_char;
    assign o_out.last       = res.last;

endmodule

`default_nettype wire

// ===== src/stsc_core.sv =====
// ----------------------------------------------------------------------------
// stsc_core: scanner state and token decode
// Holds the scan mode and the pending operator, word and number, and turns
// one registered byte into up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_core
    import stsc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_end,
    output t_push           o_push
);

    localparam logic [55:0] KW_INT   = {"int", 32'h0};
    localparam logic [55:0] KW_STR   = {"string", 8'h0};
    localparam logic [55:0] KW_VOID  = {"void", 24'h0};
    localparam logic [55:0] KW_PRINT = {"print", 16'h0};
    localparam logic [55:0] KW_IF    = {"if", 40'h0};
    localparam logic [55:0] KW_ELSE  = {"else", 24'h0};
    localparam logic [55:0] KW_FOR   = {"for", 32'h0};
    localparam logic [55:0] KW_FUNC  = {"func", 24'h0};
    localparam logic [55:0] KW_PROC  = "process";
    localparam logic [55:0] KW_THRD  = {"thread", 8'h0};
    localparam logic [55:0] KW_RET   = {"return", 8'h0};
    localparam logic [55:0] KW_AWAIT = {"await", 16'h0};

    t_mode             r_mode, n_mode;
    logic [7:0]        r_op_chars [2];
    logic [7:0]        n_op_chars [2];
    logic [1:0]        r_op_count, n_op_count;
    logic [7:0]        r_word_chars [7];
    logic [7:0]        n_word_chars [7];
    logic [3:0]        r_word_len, n_word_len;
    logic [NUM_W-1:0]  r_number_acc, n_number_acc;

    logic              c_sym, c_op, c_alpha, c_digit, c_wstart, c_wchar, c_quote, c_ws;
    logic [CODE_W-1:0] sym_code;
    logic [3:0]        digit;
    logic [34:0]       acc_next;
    logic              restart, do_start;
    logic [55:0]       word_packed;
    logic [CODE_W-1:0] op_tok, word_tok;
    t_res              res_a, res_b;
    logic              a_vld, b_vld;

    always_comb begin
        c_sym    = 1'b1;
        sym_code = TK_SEMI;
        case (i_byte)
            ";": sym_code = TK_SEMI;
            "(": sym_code = TK_LPAREN;
            ")": sym_code = TK_RPAREN;
            "{": sym_code = TK_LBRACE;
            "}": sym_code = TK_RBRACE;
            "*": sym_code = TK_STAR;
            "/": sym_code = TK_SLASH;
            ",": sym_code = TK_COMMA;
            default: c_sym = 1'b0;
        endcase
    end

    assign c_op     = (i_byte == "=") || (i_byte == "<") || (i_byte == ">") ||
                      (i_byte == "&") || (i_byte == "|") || (i_byte == "!") ||
                      (i_byte == "+") || (i_byte == "-");
    assign c_alpha  = ((i_byte >= "a") && (i_byte <= "z")) ||
                      ((i_byte >= "A") && (i_byte <= "Z"));
    assign c_digit  = (i_byte >= "0") && (i_byte <= "9");
    assign c_wstart = c_alpha || (i_byte == "_");
    assign c_wchar  = c_wstart || c_digit;
    assign c_quote  = (i_byte == 8'h22);
    assign c_ws     = (i_byte == 8'h20) || (i_byte == 8'h09) ||
                      (i_byte == 8'h0A) || (i_byte == 8'h0D);
    assign digit    = 4'(i_byte - "0");

    assign acc_next = ({4'd0, r_number_acc} << 3) + ({4'd0, r_number_acc} << 1) +
                      {31'd0, digit};

    always_comb begin
        for (int j = 0; j < 7; j++) begin
            word_packed[55-8*j -: 8] = r_word_chars[j];
        end
    end

    always_comb begin
        op_tok = TK_BAD_OP;
        if (r_op_count == 2'd1) begin
            case (r_op_chars[0])
                "=":     op_tok = TK_ASSIGN;
                "<":     op_tok = TK_LT;
                ">":     op_tok = TK_GT;
                "!":     op_tok = TK_NOT;
                "+":     op_tok = TK_PLUS;
                "-":     op_tok = TK_MINUS;
                default: op_tok = TK_BAD_OP;
            endcase
        end else if (r_op_count == 2'd2) begin
            case ({r_op_chars[0], r_op_chars[1]})
                "==":    op_tok = TK_EQ;
                "<=":    op_tok = TK_LE;
                ">=":    op_tok = TK_GE;
                "!=":    op_tok = TK_NE;
                "&&":    op_tok = TK_ANDAND;
                "||":    op_tok = TK_OROR;
                "+=":    op_tok = TK_PLUSEQ;
                "++":    op_tok = TK_INCR;
                "-=":    op_tok = TK_MINUSEQ;
                default: op_tok = TK_BAD_OP;
            endcase
        end
    end

    // unused word slots stay zero, so a full compare plus length settles a match
    always_comb begin
        word_tok = TK_IDENT;
        case (r_word_len)
            4'd2:    if (word_packed == KW_IF) word_tok = TK_KW_IF;
            4'd3: begin
                if (word_packed == KW_INT) word_tok = TK_KW_INT;
                if (word_packed == KW_FOR) word_tok = TK_KW_FOR;
            end
            4'd4: begin
                if (word_packed == KW_VOID) word_tok = TK_KW_VOID;
                if (word_packed == KW_ELSE) word_tok = TK_KW_ELSE;
                if (word_packed == KW_FUNC) word_tok = TK_KW_FUNC;
            end
            4'd5: begin
                if (word_packed == KW_PRINT) word_tok = TK_KW_PRINT;
                if (word_packed == KW_AWAIT) word_tok = TK_KW_AWAIT;
            end
            4'd6: begin
                if (word_packed == KW_STR)  word_tok = TK_KW_STR;
                if (word_packed == KW_THRD) word_tok = TK_KW_THRD;
                if (word_packed == KW_RET)  word_tok = TK_KW_RET;
            end
            4'd7:    if (word_packed == KW_PROC) word_tok = TK_KW_PROC;
            default: word_tok = TK_IDENT;
        endcase
    end

    assign restart  = (r_mode == MODE_START) ||
                      ((r_mode == MODE_OP)   && !c_op) ||
                      ((r_mode == MODE_WORD) && !c_wchar) ||
                      ((r_mode == MODE_INT)  && !c_digit);
    assign do_start = !i_end && restart;

    // next state
    always_comb begin
        n_mode       = r_mode;
        n_op_chars   = r_op_chars;
        n_op_count   = r_op_count;
        n_word_chars = r_word_chars;
        n_word_len   = r_word_len;
        n_number_acc = r_number_acc;
        if (i_end) begin
            n_mode       = MODE_START;
            n_op_chars   = '{default: 8'd0};
            n_op_count   = 2'd0;
            n_word_chars = '{default: 8'd0};
            n_word_len   = 4'd0;
            n_number_acc = '0;
        end else if (do_start) begin
            if (c_sym || c_ws) begin
                n_mode = MODE_START;
            end else if (c_op) begin
                n_mode        = MODE_OP;
                n_op_chars[0] = i_byte;
                n_op_chars[1] = 8'd0;
                n_op_count    = 2'd1;
            end else if (c_wstart) begin
                n_mode          = MODE_WORD;
                n_word_chars    = '{default: 8'd0};
                n_word_chars[0] = i_byte;
                n_word_len      = 4'd1;
            end else if (c_quote) begin
                n_mode = MODE_STR;
            end else if (c_digit) begin
                n_mode       = MODE_INT;
                n_number_acc = {27'd0, digit};
            end else begin
                n_mode = MODE_LOCK;
            end
        end else begin
            unique case (r_mode)
                MODE_START, MODE_LOCK: n_mode = r_mode;
                MODE_OP: begin
                    if (r_op_count < 2'd2) n_op_chars[r_op_count[0]] = i_byte;
                    if (r_op_count < 2'd3) n_op_count = r_op_count + 2'd1;
                end
                MODE_WORD: begin
                    if (r_word_len < 4'd7) n_word_chars[r_word_len[2:0]] = i_byte;
                    if (r_word_len < 4'd8) n_word_len = r_word_len + 4'd1;
                end
                MODE_STR: if (c_quote) n_mode = MODE_START;
                MODE_INT: n_number_acc = (acc_next > {4'd0, NUM_MAX}) ?
                                         NUM_MAX : acc_next[NUM_W-1:0];
                default: n_mode = MODE_LOCK;
            endcase
        end
    end

    // outputs: slot A is the token that a run ends with, slot B the rest
    always_comb begin
        res_a = '0;
        res_b = '0;
        a_vld = 1'b0;
        b_vld = 1'b0;
        res_a.kind = 1'b1;
        unique case (r_mode)
            MODE_OP: begin
                a_vld            = i_end || !c_op;
                res_a.token_code = op_tok;
            end
            MODE_WORD: begin
                a_vld            = i_end || !c_wchar;
                res_a.token_code = word_tok;
            end
            MODE_INT: begin
                a_vld            = i_end || !c_digit;
                res_a.token_code = TK_INTVAL;
                res_a.int_result = r_number_acc;
            end
            MODE_START, MODE_STR, MODE_LOCK: a_vld = 1'b0;
            default: a_vld = 1'b0;
        endcase

        if (i_end) begin
            b_vld            = 1'b1;
            res_b.kind       = 1'b1;
            res_b.token_code = TK_END;
        end else if (do_start) begin
            if (c_sym) begin
                b_vld            = 1'b1;
                res_b.kind       = 1'b1;
                res_b.token_code = sym_code;
            end else if (c_wstart) begin
                b_vld           = 1'b1;
                res_b.text_char = i_byte;
            end else if (!c_op && !c_quote && !c_digit && !c_ws) begin
                b_vld            = 1'b1;
                res_b.kind       = 1'b1;
                res_b.token_code = TK_ERROR;
            end
        end else if (r_mode == MODE_WORD) begin
            b_vld           = 1'b1;
            res_b.text_char = i_byte;
        end else if (r_mode == MODE_STR) begin
            b_vld = 1'b1;
            if (c_quote) begin
                res_b.kind       = 1'b1;
                res_b.token_code = TK_STRING;
            end else begin
                res_b.text_char = i_byte;
            end
        end

        o_push = '0;
        if (a_vld && b_vld) begin
            o_push.n       = 2'd2;
            o_push.r0      = res_a;
            o_push.r1      = res_b;
            o_push.r1.last = 1'b1;
        end else if (a_vld) begin
            o_push.n       = 2'd1;
            o_push.r0      = res_a;
            o_push.r0.last = 1'b1;
        end else if (b_vld) begin
            o_push.n       = 2'd1;
            o_push.r0      = res_b;
            o_push.r0.last = 1'b1;
        end
        if (!i_fire) o_push.n = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_START;
            r_op_chars   <= '{default: 8'd0};
            r_op_count   <= 2'd0;
            r_word_chars <= '{default: 8'd0};
            r_word_len   <= 4'd0;
            r_number_acc <= '0;
        end else if (i_fire) begin
            r_mode       <= n_mode;
            r_op_chars   <= n_op_chars;
            r_op_count   <= n_op_count;
            r_word_chars <= n_word_chars;
            r_word_len   <= n_word_len;
            r_number_acc <= n_number_acc;
        end
    end

endmodule

`default_nettype wire

// ===== src/stsc_resq.sv =====
// ----------------------------------------------------------------------------
// stsc_resq: result queue
// Four-entry queue that takes up to two results a cycle and hands out one while the reader is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_resq
    import stsc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_room,
    output logic       o_valid,
    output t_res       o_res,
    input  wire logic  i_ready
);

    t_res       r_mem [4];
    logic [1:0] r_wr_ptr, r_rd_ptr;
    logic [2:0] r_count;
    logic       pop;

    assign o_room  = (r_count <= 3'd2);
    assign o_valid = (r_count != 3'd0);
    assign o_res   = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) r_mem[r_wr_ptr] <= i_push.r0;
        if (i_push.n == 2'd2) r_mem[r_wr_ptr + 2'd1] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_push.n;
            r_rd_ptr <= r_rd_ptr + {1'b0, pop};
            r_count  <= r_count + {1'b0, i_push.n} - {2'b0, pop};
        end
    end

endmodule

`default_nettype wire

// ===== tb/source_token_scanner_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_token_scanner_test: self-checking bench for the source token scanner
// Streams source text (short directed lines, then random token sequences with
// noise, illegal bytes and end markers) into the byte channel. Every transfer
// goes through a cycle-free lexer kept in the bench, and each result on the
// output channel is checked field by field against the oldest predicted one.
// Both sides idle at random, and the result side holds off twice for a long
// stretch so that the scanner backs up and stalls its input.
// ----------------------------------------------------------------------------

module source_token_scanner_test;
    import stsc_pkg::*;

    localparam int          CYCLE_LIMIT = 600_000;
    localparam int          ITEM_TARGET = 2000;
    localparam int          HOLD_CYCLES = 250;
    localparam logic [5:0]  NO_CODE     = '0;
    localparam logic [7:0]  QUOTE       = 8'h22;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } src_item_t;

    logic i_clk;
    logic i_rst_n;

    stsc_in_if  in_ch ();
    stsc_out_if out_ch ();

    source_token_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Lexer state kept by the bench
    // ------------------------------------------------------------------------
    t_mode       lex_mode;
    logic [7:0]  op_buf [2];
    logic [1:0]  op_len;
    logic [55:0] word_buf;      // char j at [55-8j -: 8]
    logic [3:0]  word_count;
    logic [30:0] num_value;
    int          step_results;

    t_res        token_queue [$];
    src_item_t   source_bytes [$];

    string kw_names [12] = '{"int", "string", "void", "print", "if", "else", "for",
                             "func", "process", "thread", "return", "await"};

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_op_char(input logic [7:0] c);
        return c inside {"=", "<", ">", "&", "|", "!", "+", "-"};
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c inside {" ", "\t", "\n", "\r"};
    endfunction

    function automatic bit symbol_of(input logic [7:0] c, output logic [5:0] code);
        code = NO_CODE;
        case (c)
            ";": code = TK_SEMI;
            "(": code = TK_LPAREN;
            ")": code = TK_RPAREN;
            "{": code = TK_LBRACE;
            "}": code = TK_RBRACE;
            "*": code = TK_STAR;
            "/": code = TK_SLASH;
            ",": code = TK_COMMA;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic logic [5:0] op_token();
        if (op_len == 2'd1) begin
            case (op_buf[0])
                "=": return TK_ASSIGN;
                "<": return TK_LT;
                ">": return TK_GT;
                "!": return TK_NOT;
                "+": return TK_PLUS;
                "-": return TK_MINUS;
                default: return TK_BAD_OP;
            endcase
        end
        if (op_len == 2'd2) begin
            case ({op_buf[0], op_buf[1]})
                "==": return TK_EQ;
                "<=": return TK_LE;
                ">=": return TK_GE;
                "!=": return TK_NE;
                "&&": return TK_ANDAND;
                "||": return TK_OROR;
                "+=": return TK_PLUSEQ;
                "++": return TK_INCR;
                "-=": return TK_MINUSEQ;
                default: return TK_BAD_OP;
            endcase
        end
        return TK_BAD_OP;
    endfunction

    function automatic logic [5:0] word_token();
        case (word_count)
            4'd2: begin
                if (word_buf[55 -: 16] == "if") return TK_KW_IF;
            end
            4'd3: begin
                if (word_buf[55 -: 24] == "int") return TK_KW_INT;
                if (word_buf[55 -: 24] == "for") return TK_KW_FOR;
            end
            4'd4: begin
                if (word_buf[55 -: 32] == "void") return TK_KW_VOID;
                if (word_buf[55 -: 32] == "else") return TK_KW_ELSE;
                if (word_buf[55 -: 32] == "func") return TK_KW_FUNC;
            end
            4'd5: begin
                if (word_buf[55 -: 40] == "print") return TK_KW_PRINT;
                if (word_buf[55 -: 40] == "await") return TK_KW_AWAIT;
            end
            4'd6: begin
                if (word_buf[55 -: 48] == "string") return TK_KW_STR;
                if (word_buf[55 -: 48] == "thread") return TK_KW_THRD;
                if (word_buf[55 -: 48] == "return") return TK_KW_RET;
            end
            4'd7: begin
                if (word_buf == "process") return TK_KW_PROC;
            end
            default: ;
        endcase
        return TK_IDENT;
    endfunction

    function automatic void put_result(input logic kind, input logic [5:0] code,
                                       input logic [30:0] value, input logic [7:0] c);
        t_res r;
        r.kind       = kind;
        r.token_code = code;
        r.int_result = value;
        r.text_char  = c;
        r.last       = 1'b0;
        token_queue.push_back(r);
        step_results++;
    endfunction

    function automatic void reset_scanner();
        lex_mode   = MODE_START;
        op_buf[0]  = '0;
        op_buf[1]  = '0;
        op_len     = '0;
        word_buf   = '0;
        word_count = '0;
        num_value  = '0;
    endfunction

    function automatic void start_char(input logic [7:0] c);
        logic [5:0] sym;
        if (symbol_of(c, sym)) begin
            put_result(1'b1, sym, '0, '0);
        end else if (is_op_char(c)) begin
            op_buf[0] = c;
            op_buf[1] = '0;
            op_len    = 2'd1;
            lex_mode  = MODE_OP;
        end else if (c == "_" || is_letter(c)) begin
            word_buf          = '0;
            word_buf[55 -: 8] = c;
            word_count        = 4'd1;
            lex_mode          = MODE_WORD;
            put_result(1'b0, NO_CODE, '0, c);
        end else if (c == QUOTE) begin
            lex_mode = MODE_STR;
        end else if (is_digit_ch(c)) begin
            num_value = 31'(c - "0");
            lex_mode  = MODE_INT;
        end else if (!is_blank(c)) begin
            put_result(1'b1, TK_ERROR, '0, '0);
            lex_mode = MODE_LOCK;
        end
    endfunction

    function automatic void scan_char(input logic [7:0] c, input logic eoi);
        longint grown;
        step_results = 0;
        if (eoi) begin
            case (lex_mode)
                MODE_OP:   put_result(1'b1, op_token(), '0, '0);
                MODE_WORD: put_result(1'b1, word_token(), '0, '0);
                MODE_INT:  put_result(1'b1, TK_INTVAL, num_value, '0);
                default: ;
            endcase
            put_result(1'b1, TK_END, '0, '0);
            reset_scanner();
        end else begin
            case (lex_mode)
                MODE_START: start_char(c);
                MODE_OP: begin
                    if (is_op_char(c)) begin
                        if (op_len < 2'd2) op_buf[op_len] = c;
                        if (op_len < 2'd3) op_len++;
                    end else begin
                        put_result(1'b1, op_token(), '0, '0);
                        lex_mode = MODE_START;
                        start_char(c);
                    end
                end
                MODE_WORD: begin
                    if (c == "_" || is_letter(c) || is_digit_ch(c)) begin
                        if (word_count < 4'd7) word_buf[55 - 8 * int'(word_count) -: 8] = c;
                        if (word_count < 4'd8) word_count++;
                        put_result(1'b0, NO_CODE, '0, c);
                    end else begin
                        put_result(1'b1, word_token(), '0, '0);
                        lex_mode = MODE_START;
                        start_char(c);
                    end
                end
                MODE_STR: begin
                    if (c == QUOTE) begin
                        put_result(1'b1, TK_STRING, '0, '0);
                        lex_mode = MODE_START;
                    end else begin
                        put_result(1'b0, NO_CODE, '0, c);
                    end
                end
                MODE_INT: begin
                    if (is_digit_ch(c)) begin
                        grown = longint'(num_value) * 10 + longint'(c - "0");
                        num_value = (grown > longint'(NUM_MAX)) ? NUM_MAX : 31'(grown);
                    end else begin
                        put_result(1'b1, TK_INTVAL, num_value, '0);
                        lex_mode = MODE_START;
                        start_char(c);
                    end
                end
                default: ;
            endcase
        end
        if (step_results > 0) token_queue[token_queue.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Source text generation
    // ------------------------------------------------------------------------
    function automatic void push_char(input logic [7:0] c);
        source_bytes.push_back('{ch: c, eoi: 1'b0});
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endfunction

    function automatic void push_end();
        source_bytes.push_back('{ch: 8'($urandom_range(0, 255)), eoi: 1'b1});
    endfunction

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void add_token();
        int          sel;
        int          n;
        logic [7:0]  c;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            push_char(pick(";(){}*/,"));
        end else if (sel < 27) begin
            n = $urandom_range(0, 9);
            if (n < 3) begin
                push_char(pick("=<>!+-"));
            end else if (n < 6) begin
                case ($urandom_range(0, 8))
                    0: push_text("==");
                    1: push_text("<=");
                    2: push_text(">=");
                    3: push_text("!=");
                    4: push_text("&&");
                    5: push_text("||");
                    6: push_text("+=");
                    7: push_text("++");
                    default: push_text("-=");
                endcase
            end else if (n < 8) begin
                repeat ($urandom_range(3, 5)) push_char(pick("=<>&|!+-"));
            end else if (n < 9) begin
                push_char(pick("&|"));
            end else begin
                repeat (2) push_char(pick("=<>&|!+-"));
            end
        end else if (sel < 47) begin
            n = $urandom_range(0, 9);
            if (n < 4) begin
                push_text(kw_names[$urandom_range(0, 11)]);
            end else if (n < 5) begin
                push_text(kw_names[$urandom_range(0, 11)]);
                push_char(pick("_0123456789abcdefghijklmnopqrstuvwxyzXYZ"));
            end else begin
                push_char(pick("_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
                repeat ($urandom_range(0, 9))
                    push_char(pick("_0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
            end
        end else if (sel < 60) begin
            push_char(QUOTE);
            repeat ($urandom_range(0, 8)) begin
                c = 8'($urandom_range(0, 255));
                if (c == QUOTE) c = "'";
                push_char(c);
            end
            if ($urandom_range(0, 9) == 0) push_end();
            else push_char(QUOTE);
        end else if (sel < 78) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 5);
            repeat (n) push_char(pick("0123456789"));
        end else if (sel < 88) begin
            repeat ($urandom_range(1, 2)) push_char(pick(" \t\n\r"));
        end else if (sel < 94) begin
            push_char(8'($urandom_range(0, 255)));
        end else begin
            c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(128, 255))
                                            : 8'($urandom_range(0, 8));
            push_char(c);
            repeat ($urandom_range(0, 3)) push_char(8'($urandom_range(0, 255)));
            push_end();
        end
        if ($urandom_range(0, 9) < 4) push_char(pick(" \t\n\r"));
        if ($urandom_range(0, 24) == 0) push_end();
    endfunction

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    function automatic int next_gap(inout bit calm, inout int phase);
        if (phase == 0) begin
            calm  = ($urandom_range(0, 2) == 0);
            phase = $urandom_range(20, 150);
        end
        phase--;
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    int  src_gap   = 0;
    int  src_phase = 0;
    bit  src_calm  = 1'b0;
    int  items_sent = 0;
    int  ends_sent  = 0;

    always @(posedge i_clk) begin
        src_item_t nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                scan_char(in_ch.in_byte, in_ch.is_end);
                items_sent <= items_sent + 1;
                if (in_ch.is_end) ends_sent <= ends_sent + 1;
            end
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_ch.valid <= 1'b0;
                end else if (source_bytes.size() != 0) begin
                    nxt = source_bytes.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.in_byte <= nxt.ch;
                    in_ch.is_end  <= nxt.eoi;
                    src_gap = next_gap(src_calm, src_phase);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long hold-off of the result side
    // ------------------------------------------------------------------------
    logic sink_hold;
    int   hold_left;
    int   holds_done;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_hold  <= 1'b0;
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1) sink_hold <= 1'b0;
        end else if (holds_done < 2 && items_sent >= (holds_done + 1) * 700) begin
            sink_hold  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------------
    int sink_gap      = 0;
    int sink_phase    = 0;
    bit sink_calm     = 1'b0;
    int fail_count    = 0;
    int results_seen  = 0;
    int tokens_seen   = 0;
    int errors_seen   = 0;

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        logic rdy_next;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.kind       = out_ch.kind;
                got.token_code = out_ch.token_code;
                got.int_result = out_ch.int_result;
                got.text_char  = out_ch.text_char;
                got.last       = out_ch.last;
                results_seen++;
                if (got.kind) tokens_seen++;
                if (got.kind && got.token_code == TK_ERROR) errors_seen++;
                if (token_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result kind=%0d code=%0d int=%0d char=%02h last=%0d",
                                 $realtime, got.kind, got.token_code, got.int_result,
                                 got.text_char, got.last);
                    fail_count++;
                end else begin
                    want = token_queue.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display({"%0t: mismatch exp kind=%0d code=%0d int=%0d char=%02h ",
                                      "last=%0d / got kind=%0d code=%0d int=%0d char=%02h last=%0d"},
                                     $realtime, want.kind, want.token_code, want.int_result,
                                     want.text_char, want.last, got.kind, got.token_code,
                                     got.int_result, got.text_char, got.last);
                        fail_count++;
                    end
                end
                sink_gap = next_gap(sink_calm, sink_phase);
            end
            if (sink_hold) begin
                rdy_next = 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                rdy_next = 1'b0;
            end else begin
                rdy_next = 1'b1;
            end
            out_ch.ready <= rdy_next;
        end
    end

    // ------------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------------
    int cycle_count = 0;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, token_queue.size());
        $display("FAIL source_token_scanner");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        in_ch.is_end  = 1'b0;
        out_ch.ready  = 1'b0;
        reset_scanner();

        // directed: string with byte extremes, lone &, saturating integer,
        // longest keyword flushed by end, illegal byte then locked input
        push_char(QUOTE);
        push_char(8'hFF);
        push_char(8'h00);
        push_char(QUOTE);
        push_text("&;");
        push_text("2147483648");
        push_end();
        push_text("process");
        push_end();
        push_char(8'h00);
        push_char("x");
        push_end();

        while (source_bytes.size() < ITEM_TARGET) add_token();
        push_end();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (source_bytes.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (token_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("scanned %0d source transfers (%0d end markers) in %0d cycles",
                 items_sent, ends_sent, cycle_count);
        $display("checked %0d results: %0d tokens, %0d illegal-symbol errors, %0d failures",
                 results_seen, tokens_seen, errors_seen, fail_count);
        if (fail_count == 0) begin
            $display("PASS source_token_scanner");
        end else begin
            $display("FAIL source_token_scanner");
        end
        $finish;
    end

endmodule
